// File: rtl/core/sbte_pkg.sv
// sbte_pkg: shared types and constants for the SEED binary time converter.
// Used by sbte_decode, sbte_scale and seed_btime_to_epoch; no dependencies.

package sbte_pkg;

   localparam int WORD_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int DAYS_W  = 27;
   localparam int HMS_W   = 20;
   localparam int SECS_W  = 43;
   localparam int TICKS_W = 56;

   // 365*1970 + leaps before 1970 (478) + 1 for the one-based day of year
   localparam logic [19:0] DAYS_OFFSET = 20'd719529;

   // floor(n/100) = (n*RECIP) >> 24, floor(n/400) = (n*RECIP) >> 26, n < 2^17
   localparam logic [17:0] RECIP     = 18'd167773;
   localparam int          SH_100    = 24;
   localparam int          SH_400    = 26;

   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
   localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
   localparam logic [5:0]  SEC_PER_MIN   = 6'd60;

   localparam logic signed [17:0] SEC_PER_DAY   = 18'sd86400;
   localparam logic signed [14:0] TICKS_PER_SEC = 15'sd10000;

   typedef struct packed {
      logic                     vld;
      logic signed [DAYS_W-1:0] days;
      logic [HMS_W-1:0]         hms;
      logic [WORD_W-1:0]        frac;
   } sbte_days_type;

endpackage

// File: rtl/core/seed_btime_to_epoch.sv
// seed_btime_to_epoch: SEED binary time word to signed epoch ticks (100 us).
// Depends on sbte_pkg, sbte_decode, sbte_scale.
//
//   channel   handshake             payload
//   req_      start / busy          year, day, hour, minute, second, fraction
//   rsp_      rsp_strobe            epoch_ticks (signed 56 bit)
//   csr_      csr_wr_en             big_endian_words (1 bit, reset 1)
//
// Five-stage pipeline: a word accepted on start passes stages A, B, C, D and E to rsp_.
// One word per cycle; busy is always low since nothing can back up.
// Synchronous reset flushes all words in flight and sets big-endian order.
// The receiver cannot stall; each result is shown for exactly one cycle.

module seed_btime_to_epoch (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sbte_pkg::WORD_W-1:0]         req_year_word,
   input  logic [sbte_pkg::WORD_W-1:0]         req_day_word,
   input  logic [sbte_pkg::BYTE_W-1:0]         req_hour_byte,
   input  logic [sbte_pkg::BYTE_W-1:0]         req_minute_byte,
   input  logic [sbte_pkg::BYTE_W-1:0]         req_second_byte,
   input  logic [sbte_pkg::WORD_W-1:0]         req_fraction_word,
   output logic                                rsp_strobe,
   output logic signed [sbte_pkg::TICKS_W-1:0] rsp_epoch_ticks,
   input  logic                                csr_wr_en,
   input  logic                                csr_wr_data
);

   logic                    csr_big_endian_words_ff;
   sbte_pkg::sbte_days_type days;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_big_endian_words_ff <= 1'b1;
      end else if (csr_wr_en) begin
         csr_big_endian_words_ff <= csr_wr_data;
      end
   end

   assign busy = 1'b0;

   sbte_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .big_endian    (csr_big_endian_words_ff),
      .in_vld        (start),
      .year_word     (req_year_word),
      .day_word      (req_day_word),
      .hour_byte     (req_hour_byte),
      .minute_byte   (req_minute_byte),
      .second_byte   (req_second_byte),
      .fraction_word (req_fraction_word),
      .days_out      (days)
   );

   sbte_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .days_in   (days),
      .out_vld   (rsp_strobe),
      .out_ticks (rsp_epoch_ticks)
   );

   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_strobe)
      else $error("accepted word produced no result");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 5))
      else $error("result without accepted word");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

endmodule

// File: rtl/core/sbte_decode.sv
// sbte_decode: byte-order assembly and day count since 1970 (three stages).
// Depends on sbte_pkg.

module sbte_decode (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         big_endian,
   input  logic                         in_vld,
   input  logic [sbte_pkg::WORD_W-1:0]  year_word,
   input  logic [sbte_pkg::WORD_W-1:0]  day_word,
   input  logic [sbte_pkg::BYTE_W-1:0]  hour_byte,
   input  logic [sbte_pkg::BYTE_W-1:0]  minute_byte,
   input  logic [sbte_pkg::BYTE_W-1:0]  second_byte,
   input  logic [sbte_pkg::WORD_W-1:0]  fraction_word,
   output sbte_pkg::sbte_days_type      days_out
);

   function automatic logic [sbte_pkg::WORD_W-1:0] swap_word(
      input logic [sbte_pkg::WORD_W-1:0] w, input logic be);
      swap_word = be ? w : {w[7:0], w[15:8]};
   endfunction

   // stage A: assembled fields
   logic                        a_vld_ff;
   logic [sbte_pkg::WORD_W-1:0] a_year_ff, a_doy_ff, a_frac_ff;
   logic [sbte_pkg::BYTE_W-1:0] a_hour_ff, a_min_ff, a_sec_ff;

   // stage B: partial terms
   logic                        b_vld_ff;
   logic [24:0]                 b_y365_ff, b_y365_in;
   logic [14:0]                 b_q4_ff, b_q4_in;
   logic [10:0]                 b_q100_ff, b_q100_in;
   logic [8:0]                  b_q400_ff, b_q400_in;
   logic [sbte_pkg::HMS_W-1:0]  b_hms_ff, b_hms_in;
   logic [sbte_pkg::WORD_W-1:0] b_doy_ff, b_frac_ff;

   // stage C: day count
   sbte_pkg::sbte_days_type     c_ff, c_in;

   logic [16:0] n4, n100, n400;
   logic [34:0] p100, p400;
   logic [25:0] pos_sum;
   logic [19:0] neg_sum;

   always_comb begin
      n4        = {1'b0, a_year_ff} + 17'd3;
      n100      = {1'b0, a_year_ff} + 17'd99;
      n400      = {1'b0, a_year_ff} + 17'd399;
      p100      = {18'd0, n100} * {17'd0, sbte_pkg::RECIP};
      p400      = {18'd0, n400} * {17'd0, sbte_pkg::RECIP};
      b_q4_in   = n4[16:2];
      b_q100_in = p100[sbte_pkg::SH_100 +: 11];
      b_q400_in = p400[sbte_pkg::SH_400 +: 9];
      b_y365_in = {9'd0, a_year_ff} * {16'd0, sbte_pkg::DAYS_PER_YEAR};
      b_hms_in  = {12'd0, a_hour_ff} * {8'd0, sbte_pkg::SEC_PER_HOUR}
                + {12'd0, a_min_ff} * {14'd0, sbte_pkg::SEC_PER_MIN}
                + {12'd0, a_sec_ff};
   end

   always_comb begin
      pos_sum = {1'b0, b_y365_ff} + {11'd0, b_q4_ff} + {17'd0, b_q400_ff}
              + {10'd0, b_doy_ff};
      neg_sum = {9'd0, b_q100_ff} + sbte_pkg::DAYS_OFFSET;
      c_in.vld  = b_vld_ff;
      c_in.days = $signed({1'b0, pos_sum} - {7'd0, neg_sum});
      c_in.hms  = b_hms_ff;
      c_in.frac = b_frac_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_ff     <= '0;
      end else begin
         a_vld_ff <= in_vld;
         b_vld_ff <= a_vld_ff;
         c_ff     <= c_in;
      end
   end

   always_ff @(posedge clock) begin
      a_year_ff <= swap_word(year_word, big_endian);
      a_doy_ff  <= swap_word(day_word, big_endian);
      a_frac_ff <= swap_word(fraction_word, big_endian);
      a_hour_ff <= hour_byte;
      a_min_ff  <= minute_byte;
      a_sec_ff  <= second_byte;
      b_y365_ff <= b_y365_in;
      b_q4_ff   <= b_q4_in;
      b_q100_ff <= b_q100_in;
      b_q400_ff <= b_q400_in;
      b_hms_ff  <= b_hms_in;
      b_doy_ff  <= a_doy_ff;
      b_frac_ff <= a_frac_ff;
   end

   assign days_out = c_ff;

endmodule

// File: rtl/core/sbte_scale.sv
// sbte_scale: days to seconds to 100 us ticks (two multiply stages).
// Depends on sbte_pkg.

module sbte_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  sbte_pkg::sbte_days_type             days_in,
   output logic                                out_vld,
   output logic signed [sbte_pkg::TICKS_W-1:0] out_ticks
);

   logic                               d_vld_ff;
   logic signed [sbte_pkg::SECS_W-1:0] d_secs_ff, d_secs_in;
   logic [sbte_pkg::WORD_W-1:0]        d_frac_ff;

   logic                                e_vld_ff;
   logic signed [sbte_pkg::TICKS_W-1:0] e_ticks_ff, e_ticks_in;

   always_comb begin
      d_secs_in  = days_in.days * sbte_pkg::SEC_PER_DAY
                 + $signed({23'd0, days_in.hms});
      e_ticks_in = d_secs_ff * sbte_pkg::TICKS_PER_SEC
                 + $signed({40'd0, d_frac_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= days_in.vld;
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_secs_ff  <= d_secs_in;
      d_frac_ff  <= days_in.frac;
      e_ticks_ff <= e_ticks_in;
   end

   assign out_vld   = e_vld_ff;
   assign out_ticks = e_ticks_ff;

endmodule
